FILE: hdl/sdtq_pkg.sv
// shared types, sizes and codes for the sorted deadline timer queue
package sdtq_pkg;

  localparam int ALARM_SLOTS = 16;
  localparam int TIME_BITS   = 32;
  localparam int SLOT_W      = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1;
  localparam int CNT_W       = $clog2(ALARM_SLOTS + 1);

  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_ADD    = 2'd1,
    OP_UPDATE = 2'd2,
    OP_DELETE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_REPLY     = 2'd0,
    KIND_EXPIRED   = 2'd1,
    KIND_IDLE_TICK = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_FULL        = 2'd1,
    ST_NOT_PENDING = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    C_HOLD   = 2'd0,
    C_INSERT = 2'd1,
    C_REMOVE = 2'd2,
    C_POP    = 2'd3
  } cell_op_t;

  typedef struct packed {
    logic [TIME_BITS-1:0] deadline;
    logic [SLOT_W-1:0]    slot;
  } entry_t;

  typedef struct packed {
    cell_op_t             op;
    logic [TIME_BITS-1:0] key_deadline;
    logic [SLOT_W-1:0]    key_slot;
  } cell_cmd_t;

  typedef struct packed {
    logic              set_en;
    logic [SLOT_W-1:0] set_idx;
    logic              clr_en;
    logic [SLOT_W-1:0] clr_idx;
  } slot_ctl_t;

endpackage

FILE: hdl/sdtq_cell.sv
// one queue cell: holds an entry and shifts with its neighbors
module sdtq_cell (
  input  logic               clk,
  input  sdtq_pkg::cell_cmd_t cmd,
  input  logic               occupied,
  input  logic               left_cond,
  input  logic               left_hit,
  input  sdtq_pkg::entry_t   left_entry,
  input  sdtq_pkg::entry_t   right_entry,
  output logic               cond,
  output logic               hit,
  output sdtq_pkg::entry_t   entry
);
  import sdtq_pkg::*;

  logic match;

  // insert point lies at or before this cell
  assign cond  = !occupied || (entry.deadline >= cmd.key_deadline);
  assign match = occupied && (entry.slot == cmd.key_slot);
  assign hit   = left_hit || match;

  always_ff @(posedge clk) begin
    case (cmd.op)
      C_INSERT: begin
        if (left_cond) begin
          entry <= left_entry;
        end else if (cond) begin
          entry.deadline <= cmd.key_deadline;
          entry.slot     <= cmd.key_slot;
        end
      end
      C_REMOVE: begin
        if (hit) begin
          entry <= right_entry;
        end
      end
      C_POP: begin
        entry <= right_entry;
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: hdl/sdtq_slot_map.sv
// busy flag per alarm slot with lowest-free-slot search
module sdtq_slot_map (
  input  logic                           clk,
  input  logic                           rst,
  input  sdtq_pkg::slot_ctl_t            ctl,
  output logic [sdtq_pkg::ALARM_SLOTS-1:0] busy,
  output logic                           free_found,
  output logic [sdtq_pkg::SLOT_W-1:0]    free_idx
);
  import sdtq_pkg::*;

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = ALARM_SLOTS - 1; i >= 0; i--) begin
      if (!busy[i]) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= '0;
    end else begin
      if (ctl.clr_en) begin
        busy[ctl.clr_idx] <= 1'b0;
      end
      if (ctl.set_en) begin
        busy[ctl.set_idx] <= 1'b1;
      end
    end
  end

endmodule

FILE: hdl/sorted_deadline_timer_queue.sv
// top level: seconds counter, command sequencer and the sorted cell chain
// the reply to add, update or delete is registered and valid in the cycle after its transfer
// add runs insert, delete remove, update remove then insert; a rejected one stays idle
// a tick advances the counter, then emits one result per cycle unless the output stalls
// one command is in work at a time; the cell chain shifts at most once per cycle
// reset clears the counter, the pending count and the slot map; cell storage is not cleared
module sorted_deadline_timer_queue (
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  output logic        cmd_stall,
  input  logic [1:0]  operation,
  input  logic [3:0]  handle,
  input  logic [15:0] delay_seconds,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [1:0]  kind,
  output logic [1:0]  status,
  output logic [3:0]  result_handle,
  output logic        last
);
  import sdtq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_REMOVE = 4'b0010,
    S_INSERT = 4'b0100,
    S_EXPIRE = 4'b1000
  } state_t;

  state_t               state, state_next;
  logic [TIME_BITS-1:0] now_s, now_s_next;
  logic [CNT_W-1:0]     cnt, cnt_next;
  logic [TIME_BITS-1:0] key_deadline, key_deadline_next;
  logic [SLOT_W-1:0]    key_slot, key_slot_next;
  logic                 reinsert, reinsert_next;

  logic                 out_free, accept;
  logic                 res_load;
  kind_t                res_kind;
  status_t              res_status;
  logic [3:0]           res_handle;
  logic                 res_last;

  logic [TIME_BITS:0]   dl_sum;
  logic [TIME_BITS-1:0] dl_new;
  logic [SLOT_W-1:0]    h_slot;
  logic                 h_pending;
  logic                 head_exp, next_exp;
  op_t                  op;

  cell_cmd_t            cell_cmd;
  slot_ctl_t            slot_ctl;
  logic [ALARM_SLOTS-1:0] busy;
  logic                 free_found;
  logic [SLOT_W-1:0]    free_idx;

  entry_t               ent  [ALARM_SLOTS];
  logic                 cond [ALARM_SLOTS];
  logic                 hit  [ALARM_SLOTS];

  sdtq_slot_map u_slot_map (
    .clk        (clk),
    .rst        (rst),
    .ctl        (slot_ctl),
    .busy       (busy),
    .free_found (free_found),
    .free_idx   (free_idx)
  );

  for (genvar i = 0; i < ALARM_SLOTS; i++) begin : g_cell
    logic   occ;
    logic   lc, lh;
    entry_t le, re;
    assign occ = CNT_W'(i) < cnt;
    if (i == 0) begin : g_first
      assign lc = 1'b0;
      assign lh = 1'b0;
      assign le = ent[0];
    end else begin : g_mid
      assign lc = cond[i-1];
      assign lh = hit[i-1];
      assign le = ent[i-1];
    end
    if (i == ALARM_SLOTS - 1) begin : g_end
      assign re = ent[i];
    end else begin : g_inner
      assign re = ent[i+1];
    end
    sdtq_cell u_cell (
      .clk         (clk),
      .cmd         (cell_cmd),
      .occupied    (occ),
      .left_cond   (lc),
      .left_hit    (lh),
      .left_entry  (le),
      .right_entry (re),
      .cond        (cond[i]),
      .hit         (hit[i]),
      .entry       (ent[i])
    );
  end

  assign op        = op_t'(operation);
  assign out_free  = !res_valid || !res_stall;
  assign cmd_stall = !((state == S_IDLE) && out_free);
  assign accept    = cmd_valid && !cmd_stall;

  // deadline saturates at the top of the time range
  assign dl_sum = {1'b0, now_s} + (TIME_BITS+1)'(delay_seconds);
  assign dl_new = dl_sum[TIME_BITS] ? TIME_MAX : dl_sum[TIME_BITS-1:0];

  assign h_slot    = SLOT_W'(handle);
  assign h_pending = (32'(handle) < 32'(ALARM_SLOTS)) && busy[h_slot];

  assign head_exp = (cnt != '0) && (ent[0].deadline <= now_s);
  assign next_exp = (cnt >= CNT_W'(2)) && (ent[1].deadline <= now_s);

  always_comb begin
    state_next        = state;
    now_s_next        = now_s;
    cnt_next          = cnt;
    key_deadline_next = key_deadline;
    key_slot_next     = key_slot;
    reinsert_next     = reinsert;
    res_load          = 1'b0;
    res_kind          = KIND_REPLY;
    res_status        = ST_OK;
    res_handle        = '0;
    res_last          = 1'b1;
    cell_cmd.op           = C_HOLD;
    cell_cmd.key_deadline = key_deadline;
    cell_cmd.key_slot     = key_slot;
    slot_ctl = '0;

    case (state)
      S_IDLE: begin
        if (accept) begin
          case (op)
            OP_TICK: begin
              if (now_s != TIME_MAX) begin
                now_s_next = now_s + 1'b1;
              end
              state_next = S_EXPIRE;
            end
            OP_ADD: begin
              res_load = 1'b1;
              if (free_found) begin
                slot_ctl.set_en   = 1'b1;
                slot_ctl.set_idx  = free_idx;
                res_handle        = 4'(free_idx);
                key_deadline_next = dl_new;
                key_slot_next     = free_idx;
                state_next        = S_INSERT;
              end else begin
                res_status = ST_FULL;
              end
            end
            default: begin
              res_load = 1'b1;
              if (!h_pending) begin
                res_status = ST_NOT_PENDING;
              end else begin
                key_deadline_next = dl_new;
                key_slot_next     = h_slot;
                reinsert_next     = (op == OP_UPDATE);
                if (op == OP_DELETE) begin
                  slot_ctl.clr_en  = 1'b1;
                  slot_ctl.clr_idx = h_slot;
                end
                state_next = S_REMOVE;
              end
            end
          endcase
        end
      end
      S_REMOVE: begin
        cell_cmd.op = C_REMOVE;
        cnt_next    = cnt - 1'b1;
        state_next  = reinsert ? S_INSERT : S_IDLE;
      end
      S_INSERT: begin
        cell_cmd.op = C_INSERT;
        cnt_next    = cnt + 1'b1;
        state_next  = S_IDLE;
      end
      S_EXPIRE: begin
        if (out_free) begin
          res_load = 1'b1;
          if (head_exp) begin
            cell_cmd.op      = C_POP;
            cnt_next         = cnt - 1'b1;
            slot_ctl.clr_en  = 1'b1;
            slot_ctl.clr_idx = ent[0].slot;
            res_kind         = KIND_EXPIRED;
            res_handle       = 4'(ent[0].slot);
            res_last         = !next_exp;
            if (!next_exp) begin
              state_next = S_IDLE;
            end
          end else begin
            // tick with no expiry
            res_kind   = KIND_IDLE_TICK;
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      now_s     <= '0;
      cnt       <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      now_s <= now_s_next;
      cnt   <= cnt_next;
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    key_deadline <= key_deadline_next;
    key_slot     <= key_slot_next;
    reinsert     <= reinsert_next;
    if (res_load) begin
      kind          <= res_kind;
      status        <= res_status;
      result_handle <= res_handle;
      last          <= res_last;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(ALARM_SLOTS))
    else $error("pending count above slot count");

  a_busy_matches_cnt: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> ($countones(busy) == 32'(cnt)))
    else $error("slot map and queue occupancy disagree");

  a_head_sorted: assert property (@(posedge clk) disable iff (rst)
    (cnt >= CNT_W'(2)) |-> (ent[0].deadline <= ent[1].deadline))
    else $error("queue head out of deadline order");

  a_tick_expires: assert property (@(posedge clk) disable iff (rst)
    (accept && (op == OP_TICK)) |=> (state == S_EXPIRE))
    else $error("tick transfer did not start expiry scan");

endmodule
